>>> sv/rpac_pkg.sv
// Package: shared types, constants and constant tables for the point rotator.
`default_nettype none

package rpac_pkg;

  // Field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DEG_W   = 26;
  localparam int unsigned IN_W    = 160;  // 154 bits of fields, padded to bytes
  localparam int unsigned OUT_W   = 64;

  // Internal widths
  localparam int unsigned OFS_W = COORD_W + 1;    // point minus center
  localparam int unsigned GUARD = 16;             // extra fraction bits in the rotator
  localparam int unsigned SPLIT = 32 - GUARD;     // low part of the gain product
  localparam int unsigned PLO_W = SPLIT + 32;     // low partial product
  localparam int unsigned PHI_W = OFS_W - SPLIT + 32;  // high partial product
  localparam int unsigned PS_W  = PHI_W;          // prescaled magnitude
  localparam int unsigned XY_W  = 51;             // rotator x and y
  localparam int unsigned Z_W   = 33;             // residual phase
  localparam int unsigned PH_W  = 32;             // phase, 2^32 per turn
  localparam int unsigned RX_W  = XY_W - GUARD;   // rounded result before center add
  localparam int unsigned SUM_W = RX_W + 1;

  // Degrees to phase: 360 * 2^FRAC_BITS = DEG_DIV * 2^(FRAC_BITS + 3)
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DEG_DIV   = 45;
  localparam int unsigned DEG_SHIFT = 29 - FRAC_BITS;
  localparam int unsigned DEG_RND   = 22;          // floor of half the divisor after the shift
  localparam int unsigned MAG_W     = DEG_W;
  localparam int unsigned REC_W     = 27;
  localparam logic [REC_W-1:0] DEG_REC = REC_W'((64'd1 << 32) / DEG_DIV);
  localparam int unsigned QM_W  = 21;              // quotient of magnitude by DEG_DIV
  localparam int unsigned REM_W = 7;               // remainder before correction
  localparam int unsigned RMC_W = 6;               // remainder after correction
  localparam int unsigned LUT_W = DEG_SHIFT;

  // Phase fold limits
  localparam logic signed [Z_W-1:0] Z_QTR = Z_W'(64'd1 << 30);
  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(64'd1 << 31);

  // Saturation limits
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

  typedef logic [LUT_W-1:0] deg_lut_t [DEG_DIV];

  // Phase contribution of the remainder of the magnitude by DEG_DIV
  function automatic deg_lut_t build_deg_lut();
    deg_lut_t   lut;
    logic [31:0] num;
    for (int unsigned i = 0; i < DEG_DIV; i++) begin
      num    = (32'(i) << DEG_SHIFT) + 32'(DEG_RND);
      lut[i] = LUT_W'(num / DEG_DIV);
    end
    return lut;
  endfunction

  localparam deg_lut_t DEG_LUT = build_deg_lut();

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(int unsigned i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Inverse CORDIC gain, Q0.32, for a given stage count
  function automatic logic [31:0] inv_gain(int unsigned n);
    logic [31:0] g;
    unique case (n)
      8:  g = 32'd2608158027;
      9:  g = 32'd2608138129;
      10: g = 32'd2608133154;
      11: g = 32'd2608131911;
      12: g = 32'd2608131600;
      13: g = 32'd2608131522;
      14: g = 32'd2608131502;
      15: g = 32'd2608131498;
      default: g = 32'd2608131496;
    endcase
    return g;
  endfunction

  // Item moving down the rotator chain
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic                      flip;
  } rot_t;

  // Finished result
  typedef struct packed {
    logic                ovf;
    logic [COORD_W-1:0]  ry;
    logic [COORD_W-1:0]  rx;
  } res_t;

endpackage

`default_nettype wire

>>> sv/rpac_prep.sv
// Front end: offset from center, degrees to phase, gain prescale and quadrant fold.
`default_nettype none

module rpac_prep
  import rpac_pkg::*;
#(
  parameter logic [31:0] INV_GAIN = 32'd2608131496
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire logic signed [COORD_W-1:0] cx_i,
  input  wire logic signed [COORD_W-1:0] cy_i,
  input  wire logic signed [DEG_W-1:0]   deg_i,
  input  wire logic signed [COORD_W-1:0] px_i,
  input  wire logic signed [COORD_W-1:0] py_i,
  output logic                      valid_o,
  output rot_t                      rot_o
);

  localparam int unsigned PRD_W = MAG_W + REC_W;

  // Stage 1 registers
  logic                      v1_q;
  logic signed [COORD_W-1:0] cx1_q, cy1_q;
  logic signed [OFS_W-1:0]   dx1_q, dy1_q;
  logic                      dneg1_q;
  logic [MAG_W-1:0]          mag1_q;
  logic [QM_W-1:0]           qme1_q;
  // Stage 2 registers
  logic                      v2_q;
  logic signed [COORD_W-1:0] cx2_q, cy2_q;
  logic                      dneg2_q;
  logic [QM_W-1:0]           qm2_q;
  logic [REM_W-1:0]          rem2_q;
  logic [OFS_W-1:0]          mx2_q, my2_q;
  logic                      sx2_q, sy2_q;
  // Stage 3 registers
  logic                      v3_q;
  logic signed [COORD_W-1:0] cx3_q, cy3_q;
  logic                      dneg3_q;
  logic [QM_W-1:0]           qm3_q;
  logic [RMC_W-1:0]          rem3_q;
  logic                      sx3_q, sy3_q;
  logic [PLO_W-1:0]          plx3_q, ply3_q;
  logic [PHI_W-1:0]          phx3_q, phy3_q;
  // Stage 4 registers
  logic                      v4_q;
  logic signed [COORD_W-1:0] cx4_q, cy4_q;
  logic [PH_W-1:0]           ph4_q;
  logic                      sx4_q, sy4_q;
  logic [PS_W-1:0]           px4_q, py4_q;
  // Stage 5 registers
  logic                      v5_q;
  rot_t                      rot5_q;

  // Stage 1 logic
  logic [MAG_W-1:0]        mag_d;
  logic [PRD_W-1:0]        prd_d;
  logic signed [OFS_W-1:0] dx_d, dy_d;
  // Stage 2 logic
  logic [MAG_W-1:0]        m45_d, diff_d;
  // Stage 3 logic
  logic [QM_W-1:0]         qm_d;
  logic [RMC_W-1:0]        rem_d;
  // Stage 4 logic
  logic [QM_W+LUT_W-1:0]   t_d;
  logic [PH_W-1:0]         tl_d;
  logic [PLO_W:0]          rx_rnd_d, ry_rnd_d;
  // Stage 5 logic
  logic signed [Z_W-1:0]   zs_d;
  rot_t                    rot_d;

  // Magnitude of the angle and its estimated quotient by the divisor
  always_comb begin
    mag_d = deg_i[DEG_W-1] ? MAG_W'(-deg_i) : MAG_W'(deg_i);
    prd_d = PRD_W'(mag_d) * PRD_W'(DEG_REC);
    dx_d  = OFS_W'(px_i) - OFS_W'(cx_i);
    dy_d  = OFS_W'(py_i) - OFS_W'(cy_i);
  end

  // Remainder of the estimate
  always_comb begin
    m45_d  = MAG_W'(qme1_q) * MAG_W'(DEG_DIV);
    diff_d = mag1_q - m45_d;
  end

  // Correct an estimate that came out one low
  always_comb begin
    if (rem2_q >= REM_W'(DEG_DIV)) begin
      qm_d  = qm2_q + QM_W'(1);
      rem_d = RMC_W'(rem2_q - REM_W'(DEG_DIV));
    end else begin
      qm_d  = qm2_q;
      rem_d = RMC_W'(rem2_q);
    end
  end

  // Assemble phase and round the gain products
  always_comb begin
    t_d      = {qm3_q, DEG_LUT[rem3_q]};
    tl_d     = t_d[PH_W-1:0];
    rx_rnd_d = {1'b0, plx3_q} + (PLO_W+1)'(1 << (SPLIT - 1));
    ry_rnd_d = {1'b0, ply3_q} + (PLO_W+1)'(1 << (SPLIT - 1));
  end

  // Fold the phase into a quarter turn and sign the offsets
  always_comb begin
    zs_d       = {ph4_q[PH_W-1], ph4_q};
    rot_d.cx   = cx4_q;
    rot_d.cy   = cy4_q;
    rot_d.x    = sx4_q ? -XY_W'(px4_q) : XY_W'(px4_q);
    rot_d.y    = sy4_q ? -XY_W'(py4_q) : XY_W'(py4_q);
    rot_d.z    = zs_d;
    rot_d.flip = 1'b0;
    if (zs_d > Z_QTR) begin
      rot_d.z    = zs_d - Z_HALF;
      rot_d.flip = 1'b1;
    end else if (zs_d < -Z_QTR) begin
      rot_d.z    = zs_d + Z_HALF;
      rot_d.flip = 1'b1;
    end
  end

  // Advance stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx1_q   <= cx_i;
      cy1_q   <= cy_i;
      dx1_q   <= dx_d;
      dy1_q   <= dy_d;
      dneg1_q <= deg_i[DEG_W-1];
      mag1_q  <= mag_d;
      qme1_q  <= prd_d[PRD_W-1 -: QM_W];

      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
      dneg2_q <= dneg1_q;
      qm2_q   <= qme1_q;
      rem2_q  <= diff_d[REM_W-1:0];
      mx2_q   <= dx1_q[OFS_W-1] ? OFS_W'(-dx1_q) : OFS_W'(dx1_q);
      my2_q   <= dy1_q[OFS_W-1] ? OFS_W'(-dy1_q) : OFS_W'(dy1_q);
      sx2_q   <= dx1_q[OFS_W-1];
      sy2_q   <= dy1_q[OFS_W-1];

      cx3_q   <= cx2_q;
      cy3_q   <= cy2_q;
      dneg3_q <= dneg2_q;
      qm3_q   <= qm_d;
      rem3_q  <= rem_d;
      sx3_q   <= sx2_q;
      sy3_q   <= sy2_q;
      plx3_q  <= PLO_W'(mx2_q[SPLIT-1:0]) * PLO_W'(INV_GAIN);
      ply3_q  <= PLO_W'(my2_q[SPLIT-1:0]) * PLO_W'(INV_GAIN);
      phx3_q  <= PHI_W'(mx2_q[OFS_W-1:SPLIT]) * PHI_W'(INV_GAIN);
      phy3_q  <= PHI_W'(my2_q[OFS_W-1:SPLIT]) * PHI_W'(INV_GAIN);

      cx4_q   <= cx3_q;
      cy4_q   <= cy3_q;
      ph4_q   <= dneg3_q ? (PH_W'(0) - tl_d) : tl_d;
      sx4_q   <= sx3_q;
      sy4_q   <= sy3_q;
      px4_q   <= phx3_q + PS_W'(rx_rnd_d[PLO_W:SPLIT]);
      py4_q   <= phy3_q + PS_W'(ry_rnd_d[PLO_W:SPLIT]);

      rot5_q  <= rot_d;
    end
  end

  assign valid_o = v5_q;
  assign rot_o   = rot5_q;

endmodule

`default_nettype wire

>>> sv/rpac_cell.sv
// Rotator cell: one CORDIC micro-rotation, registered toward the next cell.
`default_nettype none

module rpac_cell
  import rpac_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   en_i,
  input  wire   valid_i,
  input  rot_t  rot_i,
  output logic  valid_o,
  output rot_t  rot_o
);

  localparam logic [31:0] ATAN = atan_turn(IDX);
  localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(ATAN);

  logic                   valid_q;
  rot_t                   rot_q;
  rot_t                   rot_d;
  logic signed [XY_W-1:0] xs, ys;

  // Turn toward zero residual phase
  always_comb begin
    xs    = $signed(rot_i.x) >>> IDX;
    ys    = $signed(rot_i.y) >>> IDX;
    rot_d = rot_i;
    if (!rot_i.z[Z_W-1]) begin
      rot_d.x = rot_i.x - ys;
      rot_d.y = rot_i.y + xs;
      rot_d.z = rot_i.z - ATAN_Z;
    end else begin
      rot_d.x = rot_i.x + ys;
      rot_d.y = rot_i.y - xs;
      rot_d.z = rot_i.z + ATAN_Z;
    end
  end

  // Hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hand payload to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;

endmodule

`default_nettype wire

>>> sv/rpac_post.sv
// Back end: undo the half-turn fold, round, add the center and saturate.
`default_nettype none

module rpac_post
  import rpac_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   en_i,
  input  wire   valid_i,
  input  rot_t  rot_i,
  output logic  valid_o,
  output res_t  res_o
);

  localparam logic signed [XY_W-1:0] HALF_LSB = XY_W'(1 << (GUARD - 1));

  logic                      va_q, vb_q;
  logic signed [XY_W-1:0]    xa_q, ya_q;
  logic signed [COORD_W-1:0] cxa_q, cya_q, cxb_q, cyb_q;
  logic signed [RX_W-1:0]    xb_q, yb_q;

  logic signed [XY_W-1:0]    xr, yr;
  logic signed [SUM_W-1:0]   sx, sy;
  logic                      ovx, ovy;

  // Round away the guard bits
  always_comb begin
    xr = (xa_q + HALF_LSB) >>> GUARD;
    yr = (ya_q + HALF_LSB) >>> GUARD;
  end

  // Add the center and clamp
  always_comb begin
    sx  = SUM_W'(xb_q) + SUM_W'(cxb_q);
    sy  = SUM_W'(yb_q) + SUM_W'(cyb_q);
    ovx = (sx > SAT_MAX) || (sx < SAT_MIN);
    ovy = (sy > SAT_MAX) || (sy < SAT_MIN);
    if (sx > SAT_MAX) begin
      res_o.rx = COORD_W'(SAT_MAX);
    end else if (sx < SAT_MIN) begin
      res_o.rx = COORD_W'(SAT_MIN);
    end else begin
      res_o.rx = COORD_W'(sx);
    end
    if (sy > SAT_MAX) begin
      res_o.ry = COORD_W'(SAT_MAX);
    end else if (sy < SAT_MIN) begin
      res_o.ry = COORD_W'(SAT_MIN);
    end else begin
      res_o.ry = COORD_W'(sy);
    end
    res_o.ovf = ovx || ovy;
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  // Advance payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q  <= rot_i.flip ? -rot_i.x : rot_i.x;
      ya_q  <= rot_i.flip ? -rot_i.y : rot_i.y;
      cxa_q <= rot_i.cx;
      cya_q <= rot_i.cy;
      xb_q  <= RX_W'(xr);
      yb_q  <= RX_W'(yr);
      cxb_q <= cxa_q;
      cyb_q <= cya_q;
    end
  end

  assign valid_o = vb_q;

endmodule

`default_nettype wire

>>> sv/rpac_obuf.sv
// Output buffer: result register plus one spare entry that frees the pipeline.
`default_nettype none

module rpac_obuf
  import rpac_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  res_t  res_i,
  input  wire   ready_i,
  output logic  en_o,
  output logic  valid_o,
  output res_t  res_o
);

  logic out_valid_q, out_valid_d;
  logic sp_valid_q, sp_valid_d;
  res_t out_q, out_d;
  res_t sp_q, sp_d;
  logic pop;
  logic push;

  assign en_o = !sp_valid_q;
  assign pop  = out_valid_q && ready_i;
  assign push = push_i && !sp_valid_q;

  // Refill the result register from the spare first, then from the pipeline
  always_comb begin
    out_valid_d = out_valid_q;
    sp_valid_d  = sp_valid_q;
    out_d       = out_q;
    sp_d        = sp_q;
    if (sp_valid_q) begin
      if (pop) begin
        out_d      = sp_q;
        sp_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_d       = res_i;
      out_valid_d = push;
    end else if (push) begin
      sp_d       = res_i;
      sp_valid_d = 1'b1;
    end
  end

  // Hold flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sp_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sp_valid_q  <= sp_valid_d;
    end
  end

  // Hold payloads
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sp_q  <= sp_d;
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

`default_nettype wire

>>> sv/rotate_point_about_center.sv
// Top level: rotation of a point about a center through a chain of CORDIC cells.
//
//  channel  dir  width  content (lowest bit first)
//  s_axis   in   160    center_x, center_y, angle_deg, point_x, point_y, zero pad
//  m_axis   out  64+1   tdata: rotated_x, rotated_y; tuser: overflow
//
//  One item per cycle enters and leaves while the output buffer has room; an item
//  passes five front stages, one cell per stage, two back stages and the output register.
//  Reset (rst_ni low) empties every stage and the output buffer at once.
//  The output buffer holds up to two results; while both entries are taken the
//  whole pipeline freezes and s_axis_tready is low.
`default_nettype none

module rotate_point_about_center
  import rpac_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire [IN_W-1:0]    s_axis_tdata,   // center_x, center_y, angle_deg, point_x, point_y
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // rotated_x, rotated_y
  output logic [0:0]        m_axis_tuser    // overflow
);

  localparam int unsigned N_ST = (CORDIC_STAGES < 8) ? 8 :
                                 ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);

  logic en;
  logic in_accept;
  logic [N_ST:0] chain_valid;
  rot_t          chain_rot [N_ST+1];
  logic          post_valid;
  res_t          post_res;
  res_t          out_res;

  logic signed [COORD_W-1:0] center_x, center_y, point_x, point_y;
  logic signed [DEG_W-1:0]   angle_deg;

  // Unpack the input item
  assign center_x  = s_axis_tdata[31:0];
  assign center_y  = s_axis_tdata[63:32];
  assign angle_deg = s_axis_tdata[89:64];
  assign point_x   = s_axis_tdata[121:90];
  assign point_y   = s_axis_tdata[153:122];

  assign s_axis_tready = en;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Front end
  rpac_prep #(
    .INV_GAIN (inv_gain(N_ST))
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_accept),
    .cx_i    (center_x),
    .cy_i    (center_y),
    .deg_i   (angle_deg),
    .px_i    (point_x),
    .py_i    (point_y),
    .valid_o (chain_valid[0]),
    .rot_o   (chain_rot[0])
  );

  // Rotator chain
  for (genvar i = 0; i < N_ST; i++) begin : g_cell
    rpac_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .rot_i   (chain_rot[i]),
      .valid_o (chain_valid[i+1]),
      .rot_o   (chain_rot[i+1])
    );
  end

  // Back end
  rpac_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[N_ST]),
    .rot_i   (chain_rot[N_ST]),
    .valid_o (post_valid),
    .res_o   (post_res)
  );

  // Output buffer
  rpac_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (post_valid),
    .res_i   (post_res),
    .ready_i (m_axis_tready),
    .en_o    (en),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.ry, out_res.rx};
  assign m_axis_tuser = out_res.ovf;

  // A blocked input means the output register is holding a result
  a_stall_has_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with empty output register");

  // Input blocks only after a result was left waiting
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input blocked without a waiting result");

  // Folded phase stays within a quarter turn
  a_phase_fold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[0] |-> ((chain_rot[0].z <= Z_QTR) && (chain_rot[0].z >= -Z_QTR)))
    else $error("phase outside a quarter turn after fold");

  // Overflow only with a clamped coordinate
  a_ovf_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      ((m_axis_tdata[31:0] == 32'h7fffffff) || (m_axis_tdata[31:0] == 32'h80000000) ||
       (m_axis_tdata[63:32] == 32'h7fffffff) || (m_axis_tdata[63:32] == 32'h80000000)))
    else $error("overflow flagged without a clamped coordinate");

endmodule

`default_nettype wire

>>> tb/rotation_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard package: bit-exact point rotation predictor and result checker.
package rotation_scoreboard_pkg;

  import rpac_pkg::IN_W;
  import rpac_pkg::OUT_W;

  localparam int unsigned    ROT_STAGES   = 16;
  localparam longint unsigned INV_GAIN_Q32 = 64'd2608131496;  // converged inverse gain
  localparam longint unsigned DEG_PER_TURN = 64'd23592960;    // 360 degrees in Q10.16
  localparam longint          QUARTER_TURN = 64'sd1073741824;
  localparam longint          HALF_TURN    = 64'sd2147483648;

  // atan(2^-i) in 2^-32 turn units, one per rotation stage
  localparam longint unsigned ATAN_TURN [0:ROT_STAGES-1] = '{
    64'd536870912, 64'd316933406, 64'd167458907, 64'd85004756,
    64'd42667331,  64'd21354465,  64'd10679838,  64'd5340245,
    64'd2670163,   64'd1335087,   64'd667544,    64'd333772,
    64'd166886,    64'd83443,     64'd41722,     64'd20861
  };

  typedef struct {
    logic [31:0] rx;
    logic [31:0] ry;
    logic        ovf;
  } rotated_t;

  // Scale an offset by the inverse gain, keeping 16 guard fraction bits
  function automatic longint scale_by_inv_gain(longint d);
    longint unsigned m;
    longint unsigned p;
    m = (d < 0) ? longint'(-d) : d;
    p = (m * INV_GAIN_Q32 + 64'd32768) >> 16;
    return (d < 0) ? -longint'(p) : longint'(p);
  endfunction

  // Clamp to the 32 bit coordinate range and flag a hit
  function automatic logic [31:0] clamp_coord(input longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      v = 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      v = -64'sd2147483648;
    end
    return v[31:0];
  endfunction

  // Rotate (px, py) about (cx, cy) by deg degrees, counter-clockwise
  function automatic rotated_t rotate_about_center(int cx, int cy, int deg, int px, int py);
    longint          ang;
    longint unsigned mag;
    longint unsigned turn;
    logic [31:0]     ph;
    longint          z;
    longint          x;
    longint          y;
    longint          xs;
    longint          ys;
    bit              flip;
    bit              hit;
    rotated_t        r;
    ang  = deg;
    mag  = (ang < 0) ? longint'(-ang) : ang;
    turn = ((mag << 32) + (DEG_PER_TURN >> 1)) / DEG_PER_TURN;
    ph   = (ang < 0) ? 32'(64'd0 - turn) : 32'(turn);
    z    = $signed(ph);
    // fold into plus or minus a quarter turn
    flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z = z - HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z = z + HALF_TURN;
      flip = 1'b1;
    end
    x = scale_by_inv_gain(longint'(px) - longint'(cx));
    y = scale_by_inv_gain(longint'(py) - longint'(cy));
    for (int i = 0; i < ROT_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURN[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURN[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    hit  = 1'b0;
    r.rx = clamp_coord(((x + 64'sd32768) >>> 16) + longint'(cx), hit);
    r.ry = clamp_coord(((y + 64'sd32768) >>> 16) + longint'(cy), hit);
    r.ovf = hit;
    return r;
  endfunction

  class rotation_scoreboard;
    rotated_t expected_q [$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predict the result of an accepted input item
    function void note_input(logic [IN_W-1:0] word);
      int cx;
      int cy;
      int deg;
      int px;
      int py;
      cx  = $signed(word[31:0]);
      cy  = $signed(word[63:32]);
      deg = $signed(word[89:64]);
      px  = $signed(word[121:90]);
      py  = $signed(word[153:122]);
      expected_q.push_back(rotate_about_center(cx, cy, deg, px, py));
    endfunction

    // Compare an accepted result item with the oldest prediction
    function void check_result(logic [OUT_W-1:0] word, logic ovf);
      rotated_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: x %h y %h ovf %b",
                 $time, word[31:0], word[63:32], ovf);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (word[31:0] !== want.rx) begin
        $display("%0t: rotated_x expected %h actual %h", $time, want.rx, word[31:0]);
        errors++;
      end
      if (word[63:32] !== want.ry) begin
        $display("%0t: rotated_y expected %h actual %h", $time, want.ry, word[63:32]);
        errors++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, want.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives random and directed points through the rotator and checks results.
module tb_top;
  import rpac_pkg::IN_W;
  import rpac_pkg::OUT_W;
  import rotation_scoreboard_pkg::*;

  localparam int DEG_MAX    = 23592960;   // +360 degrees
  localparam int DEG_90     = 5898240;
  localparam int COORD_MAX  = 32'sh7fffffff;
  localparam int COORD_MIN  = 32'sh80000000;
  localparam int HANG_LIMIT = 1000;
  localparam int DRAIN_WAIT = 40;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tready = 1'b0;
  wire              s_axis_tready;
  wire              m_axis_tvalid;
  wire [OUT_W-1:0]  m_axis_tdata;
  wire [0:0]        m_axis_tuser;

  rotation_scoreboard sb = new();
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;

  rotate_point_about_center #(
    .CORDIC_STAGES(ROT_STAGES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  // Stall the result side at random
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(99) < 30) begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Record accepted items on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one point and hold it until accepted
  task automatic send_point(input int cx, input int cy, input int deg,
                            input int px, input int py);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, py, px, 26'(deg), cy, cx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Coordinate near the ends of the range, near zero, or anywhere in it
  function automatic int edge_coord();
    case ($urandom_range(3))
      0: return COORD_MAX - int'($urandom_range(255));
      1: return COORD_MIN + int'($urandom_range(255));
      2: return int'($urandom_range(511)) - 256;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_point();
    int cx;
    int cy;
    int deg;
    int px;
    int py;
    int r;
    // pick coordinates: full range, small offsets, or near the edges
    r = $urandom_range(9);
    if (r < 4) begin
      cx = $urandom;
      cy = $urandom;
      px = $urandom;
      py = $urandom;
    end else if (r < 8) begin
      cx = int'($urandom_range(2097152)) - 1048576;
      cy = int'($urandom_range(2097152)) - 1048576;
      px = cx + int'($urandom_range(262144)) - 131072;
      py = cy + int'($urandom_range(262144)) - 131072;
    end else begin
      cx = edge_coord();
      cy = edge_coord();
      px = edge_coord();
      py = edge_coord();
    end
    // pick the angle: uniform, near a multiple of a quarter turn, or tiny
    r = $urandom_range(99);
    if (r < 70) begin
      deg = int'($urandom_range(2 * DEG_MAX)) - DEG_MAX;
    end else if (r < 85) begin
      deg = (int'($urandom_range(8)) - 4) * DEG_90 + int'($urandom_range(6)) - 3;
      if (deg > DEG_MAX) deg = DEG_MAX;
      if (deg < -DEG_MAX) deg = -DEG_MAX;
    end else begin
      deg = int'($urandom_range(64)) - 32;
    end
    send_point(cx, cy, deg, px, py);
  endtask

  // Wait until every predicted result has arrived
  task automatic drain_results();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: quarter-turn angles, fold boundaries, range ends, overflow
    send_point(0, 0, 0, 0, 0);
    send_point(0, 0, DEG_90, 65536, 0);
    send_point(0, 0, -DEG_90, 65536, 0);
    send_point(65536, -65536, 2 * DEG_90, 131072, 65536);
    send_point(65536, -65536, -2 * DEG_90, 131072, 65536);
    send_point(0, 0, 3 * DEG_90, 65536, 65536);
    send_point(0, 0, -3 * DEG_90, 65536, 65536);
    send_point(1000, 2000, DEG_MAX, 700000, -300000);
    send_point(1000, 2000, -DEG_MAX, 700000, -300000);
    send_point(0, 0, DEG_90 + 1, 65536, 0);
    send_point(0, 0, DEG_90 - 1, 65536, 0);
    send_point(0, 0, -DEG_90 - 1, 65536, 0);
    send_point(0, 0, DEG_90 / 2, 65536 * 100, 0);
    send_point(0, 0, 1, 65536 * 1000, 65536 * 1000);
    send_point(0, 0, -1, 65536 * 1000, 65536 * 1000);
    send_point(COORD_MAX, 0, 2 * DEG_90, COORD_MIN, 0);
    send_point(COORD_MIN, 0, 2 * DEG_90, COORD_MAX, 0);
    send_point(COORD_MIN, COORD_MIN, 0, COORD_MAX, COORD_MAX);
    send_point(COORD_MAX, COORD_MIN, DEG_90, COORD_MIN, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, -DEG_90, COORD_MAX, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, 37 * 65536, COORD_MAX, COORD_MAX);
    send_point(-1, -1, -DEG_MAX, COORD_MIN, -1);

    // random phases with every mix of sender gaps and receiver stalls
    for (int phase = 0; phase < 8; phase++) begin
      gaps_on   = phase[0];
      stalls_on = phase[1] | phase[2];
      repeat (240) send_random_point();
      if (phase == 3) begin
        // hold the sender until the pipeline is empty
        s_axis_tvalid <= 1'b0;
        drain_results();
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
